FILE: src/vpe_pkg.sv
// shared types, constants and helpers for the voxel particle engine
package vpe_pkg;
	localparam int CubeSideDef = 8;
	localparam int SlotsDef = 16;
	localparam int QScale = 16;

	localparam logic [1:0] CMD_EMIT = 2'd0;
	localparam logic [1:0] CMD_STEP = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam logic [2:0] KIND_EMITTED = 3'd0;
	localparam logic [2:0] KIND_NO_SLOTS = 3'd1;
	localparam logic [2:0] KIND_BAD_COORD = 3'd2;
	localparam logic [2:0] KIND_DRAW = 3'd3;
	localparam logic [2:0] KIND_STEP_DONE = 3'd4;
	localparam logic [2:0] KIND_CLEARED = 3'd5;

	localparam logic [1:0] REG_SLOT_COUNT = 2'd0;
	localparam logic [1:0] REG_GRAVITY = 2'd1;
	localparam logic [1:0] REG_DRAG = 2'd2;
	localparam logic [1:0] REG_INITIAL_LIFE = 2'd3;

	typedef struct packed {
		logic [1:0] cmd;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] pos_z;
		logic signed [7:0] vel_x;
		logic signed [7:0] vel_y;
		logic signed [7:0] vel_z;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} in_item_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [2:0] voxel_x;
		logic [2:0] voxel_y;
		logic [2:0] voxel_z;
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic last;
	} out_item_t;

	typedef struct packed {
		logic [2:0] index;
		logic [7:0] data;
	} cfg_item_t;

	// controller to datapath
	typedef struct packed {
		logic load;       // capture input item, reset walk
		logic scan_rd;    // issue read of current slot
		logic scan_evl;   // evaluate read data
		logic emit_wr;    // write selected slot
		logic step_wr;    // write back stepped slot
		logic clear;      // clear all active bits
		logic adv;        // advance slot index
		logic sel_first;  // pick the current slot as emit target
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [1:0] cmd;
		logic no_slots;
		logic bad_coord;
		logic at_end;
		logic cur_active;
		logic survive;
	} sts_t;

	// truncating division of a signed product by 255
	function automatic logic signed [7:0] div255(input logic signed [16:0] p);
		logic [16:0] a;
		logic [24:0] m;
		logic [8:0] q;
		logic [16:0] r;
		begin
			a = p[16] ? 17'(-p) : p;
			m = 25'(a) * 25'd257;
			q = 9'(m >> 16);
			r = a - 17'(q) * 17'd255;
			if (r >= 17'd255) q = q + 9'd1;
			div255 = p[16] ? 8'(-q) : 8'(q);
		end
	endfunction
endpackage

FILE: src/vpe_if.sv
// valid/ready channel interfaces
interface vpe_in_if;
	logic valid;
	logic ready;
	vpe_pkg::in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface vpe_out_if;
	logic valid;
	logic ready;
	vpe_pkg::out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface vpe_cfg_if;
	logic valid;
	logic ready;
	vpe_pkg::cfg_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: src/vpe_datapath.sv
// slot table, config registers and particle arithmetic
module vpe_datapath #(
	parameter int CUBE_SIDE = vpe_pkg::CubeSideDef,
	parameter int PARTICLE_SLOTS = vpe_pkg::SlotsDef
) (
	input  logic clk,
	input  logic arst_n,
	input  vpe_pkg::in_item_t in_data,
	input  logic cfg_we,
	input  vpe_pkg::cfg_item_t cfg_data,
	input  vpe_pkg::cmd_t ctl,
	output vpe_pkg::sts_t sts,
	output logic [2:0] dv_x,
	output logic [2:0] dv_y,
	output logic [2:0] dv_z,
	output logic [23:0] dcol
);
	import vpe_pkg::*;
	localparam int IW = (PARTICLE_SLOTS > 1) ? $clog2(PARTICLE_SLOTS) : 1;
	localparam int CW = $clog2(PARTICLE_SLOTS + 1);
	localparam int PW = $clog2(CUBE_SIDE * QScale);
	localparam int QMAX = CUBE_SIDE * QScale - 1;
	localparam int MW = 3 * PW + 24 + 8 + 24;

	logic [4:0] slot_count_q;
	logic signed [7:0] gravity_q;
	logic [7:0] drag_q, life_init_q;
	in_item_t item_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] n_w;
	logic [PARTICLE_SLOTS-1:0] active_q;
	logic [MW-1:0] mem [PARTICLE_SLOTS];
	logic [MW-1:0] rd_q;
	logic [IW-1:0] sel_q;
	logic [7:0] sel_life_q;
	logic [IW-1:0] idx_w;

	logic [PW-1:0] px, py, pz;
	logic signed [7:0] vx, vy, vz;
	logic [7:0] life;
	logic [23:0] col;
	logic signed [8:0] vy_g;
	logic signed [7:0] vy_s, nvx, nvy, nvz;
	logic signed [16:0] prod_x_s1, prod_y_s1, prod_z_s1;
	logic signed [PW+1:0] npx, npy, npz;
	logic [7:0] nlife;
	logic [MW-1:0] wr_d;

	assign idx_w = idx_q[IW-1:0];
	assign n_w = (int'(slot_count_q) > PARTICLE_SLOTS) ? CW'(PARTICLE_SLOTS) : CW'(slot_count_q);
	assign {px, py, pz, vx, vy, vz, life, col} = rd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q <= 5'd0;
			gravity_q <= 8'sd0;
			drag_q <= 8'd255;
			life_init_q <= 8'd1;
		end else if (cfg_we) begin
			case (cfg_data.index)
				3'(REG_SLOT_COUNT): slot_count_q <= cfg_data.data[4:0];
				3'(REG_GRAVITY): gravity_q <= cfg_data.data;
				3'(REG_DRAG): drag_q <= cfg_data.data;
				3'(REG_INITIAL_LIFE): life_init_q <= cfg_data.data;
				default: ;
			endcase
		end
	end

	// drag products of the slot read back, registered before use
	always_ff @(posedge clk) begin
		prod_x_s1 <= 17'(vx) * $signed({9'd0, drag_q});
		prod_y_s1 <= 17'(vy_s) * $signed({9'd0, drag_q});
		prod_z_s1 <= 17'(vz) * $signed({9'd0, drag_q});
	end

	always_ff @(posedge clk) begin
		if (ctl.load) item_q <= in_data;
		if (ctl.scan_rd) rd_q <= mem[idx_w];
		if (ctl.emit_wr)
			mem[sel_q] <= {PW'(item_q.pos_x[7:0] * 8'(QScale)),
				PW'(item_q.pos_y[7:0] * 8'(QScale)), PW'(item_q.pos_z[7:0] * 8'(QScale)),
				item_q.vel_x, item_q.vel_y, item_q.vel_z, life_init_q,
				item_q.red, item_q.green, item_q.blue};
		if (ctl.step_wr) mem[idx_w] <= wr_d;
		if (ctl.load) begin
			sel_q <= '0;
			sel_life_q <= '0;
		end else if (ctl.sel_first) begin
			sel_q <= idx_w;
		end else if (ctl.scan_evl && (idx_q == '0 || life < sel_life_q)) begin
			sel_q <= idx_w;
			sel_life_q <= life;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			idx_q <= '0;
		end else begin
			if (ctl.load) idx_q <= '0;
			else if (ctl.adv) idx_q <= idx_q + CW'(1);
			if (ctl.clear) active_q <= '0;
			else if (ctl.emit_wr) active_q[sel_q] <= 1'b1;
			else if (ctl.step_wr && !sts.survive) active_q[idx_w] <= 1'b0;
		end
	end

	always_comb begin
		vy_g = 9'(vy) + 9'(gravity_q);
		vy_s = (vy_g < -9'sd128) ? -8'sd128 : (vy_g > 9'sd127) ? 8'sd127 : 8'(vy_g);
		nvx = div255(prod_x_s1);
		nvy = div255(prod_y_s1);
		nvz = div255(prod_z_s1);
		npx = $signed({2'b00, px}) + (PW+2)'(nvx);
		npy = $signed({2'b00, py}) + (PW+2)'(nvy);
		npz = $signed({2'b00, pz}) + (PW+2)'(nvz);
		nlife = life - 8'd1;
		wr_d = {npx[PW-1:0], npy[PW-1:0], npz[PW-1:0], nvx, nvy, nvz, nlife, col};
	end

	assign sts.cmd = item_q.cmd;
	assign sts.no_slots = (n_w == '0);
	assign sts.bad_coord = item_q.pos_x < 0 || item_q.pos_x >= 16'(CUBE_SIDE)
		|| item_q.pos_y < 0 || item_q.pos_y >= 16'(CUBE_SIDE)
		|| item_q.pos_z < 0 || item_q.pos_z >= 16'(CUBE_SIDE);
	assign sts.at_end = (idx_q >= n_w);
	assign sts.cur_active = active_q[idx_w];
	assign sts.survive = nlife != 8'd0 && npx >= 0 && npx <= (PW+2)'(QMAX)
		&& npy >= 0 && npy <= (PW+2)'(QMAX) && npz >= 0 && npz <= (PW+2)'(QMAX);
	assign dv_x = 3'(npx[PW-1:4]);
	assign dv_y = 3'(npy[PW-1:4]);
	assign dv_z = 3'(npz[PW-1:4]);
	assign dcol = col;
endmodule

FILE: src/vpe_ctrl.sv
// command sequencer walking the slot table
module vpe_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output logic [2:0] out_kind,
	output logic out_last,
	output logic out_draw,
	output vpe_pkg::cmd_t ctl,
	input  vpe_pkg::sts_t sts
);
	import vpe_pkg::*;
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DEC = 3'd1;
	localparam logic [2:0] S_RD = 3'd2;
	localparam logic [2:0] S_EVL = 3'd3;
	localparam logic [2:0] S_WR = 3'd4;
	localparam logic [2:0] S_OUT = 3'd5;

	logic [2:0] state_q;
	logic [2:0] kind_q;
	logic last_q, ov_q, draw_q, found_q;
	logic room, ov_set;

	assign room = !ov_q || out_ready;
	assign in_ready = (state_q == S_IDLE);
	assign out_valid = ov_q;
	assign out_kind = kind_q;
	assign out_last = last_q;
	assign out_draw = draw_q;

	always_comb begin
		ctl = '0;
		ctl.load = in_valid && state_q == S_IDLE;
		case (state_q)
			S_RD: begin
				ctl.scan_rd = !sts.at_end;
				ctl.adv = sts.cmd == CMD_STEP && !sts.at_end && !sts.cur_active;
			end
			S_EVL: begin
				if (sts.cmd == CMD_EMIT) begin
					ctl.scan_evl = sts.cur_active;
					ctl.sel_first = !sts.cur_active;
					ctl.adv = 1'b1;
				end
			end
			S_WR: begin
				if (sts.cmd == CMD_EMIT) ctl.emit_wr = room;
				else if (room || !sts.survive) begin
					ctl.step_wr = 1'b1;
					ctl.adv = 1'b1;
				end
			end
			S_DEC: begin
				ctl.clear = sts.cmd == CMD_CLEAR && room;
			end
			default: ;
		endcase
	end

	// a new item enters the output register
	always_comb begin
		ov_set = 1'b0;
		case (state_q)
			S_DEC: ov_set = room && sts.cmd != CMD_STEP && sts.cmd != CMD_UNUSED
				&& !(sts.cmd == CMD_EMIT && !sts.no_slots && !sts.bad_coord);
			S_WR: ov_set = room && (sts.cmd == CMD_EMIT || sts.survive);
			S_OUT: ov_set = room;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ov_q <= 1'b0;
			kind_q <= KIND_EMITTED;
			last_q <= 1'b0;
			draw_q <= 1'b0;
			found_q <= 1'b0;
		end else begin
			if (ov_set) ov_q <= 1'b1;
			else if (out_ready) ov_q <= 1'b0;
			case (state_q)
				S_IDLE: if (in_valid) begin
					state_q <= S_DEC;
					found_q <= 1'b0;
				end
				S_DEC: begin
					if (sts.cmd == CMD_STEP) state_q <= S_RD;
					else if (sts.cmd == CMD_EMIT && !sts.no_slots && !sts.bad_coord)
						state_q <= S_RD;
					else if (sts.cmd == CMD_UNUSED) state_q <= S_IDLE;
					else if (room) begin
						last_q <= 1'b1;
						draw_q <= 1'b0;
						kind_q <= sts.cmd == CMD_CLEAR ? KIND_CLEARED
							: sts.no_slots ? KIND_NO_SLOTS : KIND_BAD_COORD;
						state_q <= S_IDLE;
					end
				end
				S_RD: begin
					if (sts.at_end || (sts.cmd == CMD_EMIT && found_q)) begin
						state_q <= sts.cmd == CMD_EMIT ? S_WR : S_OUT;
					end else if (sts.cmd == CMD_STEP && !sts.cur_active) begin
						state_q <= S_RD;
					end else begin
						state_q <= S_EVL;
					end
				end
				S_EVL: begin
					if (sts.cmd == CMD_EMIT) begin
						found_q <= !sts.cur_active;
						state_q <= S_RD;
					end else state_q <= S_WR;
				end
				S_WR: begin
					if (sts.cmd == CMD_EMIT) begin
						if (room) begin
							last_q <= 1'b1;
							draw_q <= 1'b0;
							kind_q <= KIND_EMITTED;
							state_q <= S_IDLE;
						end
					end else if (!sts.survive) state_q <= S_RD;
					else if (room) begin
						last_q <= 1'b0;
						draw_q <= 1'b1;
						kind_q <= KIND_DRAW;
						state_q <= S_RD;
					end
				end
				S_OUT: if (room) begin
					last_q <= 1'b1;
					draw_q <= 1'b0;
					kind_q <= KIND_STEP_DONE;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_one_wr: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.emit_wr && ctl.step_wr)) else $error("two writes at once");
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !ctl.emit_wr && !ctl.step_wr) else $error("busy while ready");
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && kind_q == KIND_DRAW) |-> !last_q) else $error("draw marked last");
endmodule

FILE: src/voxel_particle_engine_unit.sv
// Particle engine top level. One command is in flight at a time and the controller walks the
// slot table slot by slot, so the time of an item is set by the slot count in use.
// Emit scans the slots up to the first free one, or every slot in use when none is free; step
// reads each slot in use and writes back only the active ones; clear, refused emits and the
// unused command are settled in the decode state. A result waiting on a stalled output holds
// the walk for the length of the stall. At most one slot of the table is read or written per
// cycle; results leave through a registered output stage.
module voxel_particle_engine_unit #(
	parameter int CUBE_SIDE = vpe_pkg::CubeSideDef,
	parameter int PARTICLE_SLOTS = vpe_pkg::SlotsDef
) (
	input logic clk,
	input logic arst_n,
	vpe_in_if.sink in_ch,
	vpe_out_if.source out_ch,
	vpe_cfg_if.sink cfg_ch
);
	import vpe_pkg::*;
	cmd_t ctl;
	sts_t sts;
	logic [2:0] dv_x, dv_y, dv_z, kind;
	logic [23:0] dcol;
	logic last, draw;
	logic [2:0] vx_q, vy_q, vz_q;
	logic [23:0] col_q;

	assign cfg_ch.ready = 1'b1;

	vpe_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.out_kind(kind), .out_last(last), .out_draw(draw),
		.ctl, .sts
	);

	vpe_datapath #(.CUBE_SIDE(CUBE_SIDE), .PARTICLE_SLOTS(PARTICLE_SLOTS)) u_dp (
		.clk, .arst_n,
		.in_data(in_ch.data),
		.cfg_we(cfg_ch.valid), .cfg_data(cfg_ch.data),
		.ctl, .sts, .dv_x, .dv_y, .dv_z, .dcol
	);

	always_ff @(posedge clk) begin
		if (ctl.step_wr && sts.survive) begin
			vx_q <= dv_x;
			vy_q <= dv_y;
			vz_q <= dv_z;
			col_q <= dcol;
		end
	end

	assign out_ch.data.kind = kind;
	assign out_ch.data.last = last;
	assign out_ch.data.voxel_x = draw ? vx_q : 3'd0;
	assign out_ch.data.voxel_y = draw ? vy_q : 3'd0;
	assign out_ch.data.voxel_z = draw ? vz_q : 3'd0;
	assign out_ch.data.out_red = draw ? col_q[23:16] : 8'd0;
	assign out_ch.data.out_green = draw ? col_q[15:8] : 8'd0;
	assign out_ch.data.out_blue = draw ? col_q[7:0] : 8'd0;
endmodule
